// ===== sv/clt_pkg.sv =====
// Shared types, constants and helpers of the client lease table.
package clt_pkg;

   localparam int LEASE_SLOTS = 8;
   localparam int SLOT_W      = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
   localparam int CNT_W       = $clog2(LEASE_SLOTS + 1);
   localparam int MAC_W       = 48;
   localparam int TIME_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int SLOT_OUT_W  = 3;
   localparam int MASK_W      = 8;
   localparam int COUNT_OUT_W = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE     = 1'd1;

   localparam logic [TIME_W-1:0] MAX_LEASE_RESET = 32'd3600000;
   localparam logic [TIME_W-1:0] STALE_RESET     = 32'd60000;

   typedef logic [SLOT_W-1:0] slot_idx_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [MAC_W-1:0]  mac_type;
   typedef logic [TIME_W-1:0] time_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REFRESHED  = 2'd0,
      ST_ADDED      = 2'd1,
      ST_FULL       = 2'd2,
      ST_SWEEP_DONE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SOP_NONE,
      SOP_REFRESH,
      SOP_ALLOC,
      SOP_REMOVE,
      SOP_CLEAR_SEEN
   } store_op_type;

   typedef enum logic {
      CMP_MAC_EQ,
      CMP_AGE_GT
   } cmp_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_DECIDE,
      S_AGE_LEASE,
      S_AGE_STALE,
      S_SWEEP_END
   } state_type;

   typedef struct packed {
      mac_type  mac;
      time_type start;
      time_type last_seen;
   } entry_type;

   typedef struct packed {
      store_op_type op;
      slot_idx_type slot;
      mac_type      mac;
      time_type     now;
   } store_cmd_type;

   function automatic logic [SLOT_OUT_W-1:0] slot_field(slot_idx_type s);
      logic [63:0] w;
      w = 64'(s);
      return w[SLOT_OUT_W-1:0];
   endfunction

   function automatic logic [COUNT_OUT_W-1:0] count_field(count_type c);
      logic [63:0] w;
      w = 64'(c);
      return w[COUNT_OUT_W-1:0];
   endfunction

endpackage

// ===== sv/clt_req_if.sv =====
// Request channel of the client lease table: station and sweep items.
interface clt_req_if;
   import clt_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [MAC_W-1:0]  station_mac;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, kind, station_mac, now_ms, input ready);
   modport sink   (input valid, kind, station_mac, now_ms, output ready);
endinterface

// ===== sv/clt_rsp_if.sv =====
// Response channel of the client lease table: one result item per request.
interface clt_rsp_if;
   import clt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [SLOT_OUT_W-1:0]  slot;
   logic [MASK_W-1:0]      removed_mask;
   logic [COUNT_OUT_W-1:0] lease_count;

   modport source (output valid, status, slot, removed_mask, lease_count, input ready);
   modport sink   (input valid, status, slot, removed_mask, lease_count, output ready);
endinterface

// ===== sv/client_lease_table_top.sv =====
// Client lease table: MAC-keyed lease slots with refresh, allocation and aging.
//
// req carries an item: kind 0 reports a station (station_mac, now_ms), kind 1
// sweeps the table at now_ms. rsp returns one item per request: status, slot,
// removed_mask of slots dropped by a sweep, and lease_count afterwards.
// csr_wr_en/csr_index/csr_wdata write max_lease_ms (index 0) or stale_ms
// (index 1); write them only while no request is in flight.
// req.ready is high only while the sequencer is idle. A station item walks the
// slots through the shared compare unit, one slot a cycle, stopping at a MAC
// match, then decides in a final step (S_DECIDE) that writes the result to rsp.
// A sweep checks each slot's lease age and, for a valid slot still within its
// lease, its idle time against stale_ms, then finishes in S_SWEEP_END. The
// result waits in an output register; a new request is taken while it waits,
// and that item only stalls at its last step if the earlier result is still
// held by rsp.ready low.
// Reset (synchronous, active high) empties the table, zeroes the count and
// restores the register defaults.
module client_lease_table_top (
   input  logic                              clock,
   input  logic                              reset,
   clt_req_if.sink                           req,
   clt_rsp_if.source                         rsp,
   input  logic                              csr_wr_en,
   input  logic [clt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [clt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import clt_pkg::*;

   time_type      max_lease_ff, max_lease_in;
   time_type      stale_ff, stale_in;
   slot_idx_type  rd_slot;
   store_cmd_type cmd;
   entry_type     rd_entry;
   logic          rd_valid;
   logic          rd_seen;
   count_type     count;
   cmp_op_type    cmp_op;
   mac_type       cmp_a;
   mac_type       cmp_b;
   time_type      cmp_limit;
   logic          cmp_hit;

   always_comb begin
      max_lease_in = max_lease_ff;
      stale_in     = stale_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_LEASE: max_lease_in = csr_wdata[TIME_W-1:0];
            CSR_STALE:     stale_in     = csr_wdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lease_ff <= MAX_LEASE_RESET;
         stale_ff     <= STALE_RESET;
      end else begin
         max_lease_ff <= max_lease_in;
         stale_ff     <= stale_in;
      end
   end

   clt_slot_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_slot  (rd_slot),
      .cmd      (cmd),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid),
      .rd_seen  (rd_seen),
      .count    (count)
   );

   clt_cmp_unit u_cmp (
      .op    (cmp_op),
      .a     (cmp_a),
      .b     (cmp_b),
      .limit (cmp_limit),
      .hit   (cmp_hit)
   );

   clt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .max_lease (max_lease_ff),
      .stale     (stale_ff),
      .rd_slot   (rd_slot),
      .cmd       (cmd),
      .rd_entry  (rd_entry),
      .rd_valid  (rd_valid),
      .rd_seen   (rd_seen),
      .count     (count),
      .cmp_op    (cmp_op),
      .cmp_a     (cmp_a),
      .cmp_b     (cmp_b),
      .cmp_limit (cmp_limit),
      .cmp_hit   (cmp_hit)
   );

endmodule

// ===== sv/clt_slot_store.sv =====
// Lease slot storage: per-slot MAC and times, valid and seen marks, lease count.
module clt_slot_store (
   input  logic                   clock,
   input  logic                   reset,
   input  clt_pkg::slot_idx_type  rd_slot,
   input  clt_pkg::store_cmd_type cmd,
   output clt_pkg::entry_type     rd_entry,
   output logic                   rd_valid,
   output logic                   rd_seen,
   output clt_pkg::count_type     count
);
   import clt_pkg::*;

   entry_type              entry_ff [LEASE_SLOTS];
   logic [LEASE_SLOTS-1:0] valid_ff, valid_in;
   logic [LEASE_SLOTS-1:0] seen_ff, seen_in;
   count_type              count_ff, count_in;

   assign rd_entry = entry_ff[rd_slot];
   assign rd_valid = valid_ff[rd_slot];
   assign rd_seen  = seen_ff[rd_slot];
   assign count    = count_ff;

   always_comb begin
      valid_in = valid_ff;
      seen_in  = seen_ff;
      count_in = count_ff;
      case (cmd.op)
         SOP_REFRESH: begin
            seen_in[cmd.slot] = 1'b1;
         end
         SOP_ALLOC: begin
            valid_in[cmd.slot] = 1'b1;
            seen_in[cmd.slot]  = 1'b1;
            count_in           = count_ff + 1'b1;
         end
         SOP_REMOVE: begin
            valid_in[cmd.slot] = 1'b0;
            seen_in[cmd.slot]  = 1'b0;
            count_in           = count_ff - 1'b1;
         end
         SOP_CLEAR_SEEN: begin
            seen_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         seen_ff  <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
         count_ff <= count_in;
      end
   end

   // Payload needs no reset: it is only looked at behind its valid mark.
   always_ff @(posedge clock) begin
      case (cmd.op)
         SOP_REFRESH: begin
            entry_ff[cmd.slot].last_seen <= cmd.now;
         end
         SOP_ALLOC: begin
            entry_ff[cmd.slot].mac       <= cmd.mac;
            entry_ff[cmd.slot].start     <= cmd.now;
            entry_ff[cmd.slot].last_seen <= cmd.now;
         end
         default: begin
         end
      endcase
   end

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(valid_ff))
      else $error("lease count differs from number of valid slots");

   a_alloc_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.op == SOP_ALLOC |-> !valid_ff[cmd.slot])
      else $error("allocation into an occupied slot");

   a_touch_valid_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == SOP_REMOVE || cmd.op == SOP_REFRESH) |-> valid_ff[cmd.slot])
      else $error("refresh or removal of an empty slot");

endmodule

// ===== sv/clt_cmp_unit.sv =====
// Shared compare unit: MAC equality or wrapped age against a limit.
module clt_cmp_unit (
   input  clt_pkg::cmp_op_type op,
   input  clt_pkg::mac_type    a,
   input  clt_pkg::mac_type    b,
   input  clt_pkg::time_type   limit,
   output logic                hit
);
   import clt_pkg::*;

   time_type age;

   // Age wraps modulo 2^32.
   assign age = a[TIME_W-1:0] - b[TIME_W-1:0];

   always_comb begin
      case (op)
         CMP_MAC_EQ: hit = (a == b);
         CMP_AGE_GT: hit = (age > limit);
         default:    hit = 1'b0;
      endcase
   end

endmodule

// ===== sv/clt_seq.sv =====
// Sequencer: walks the slots one at a time through the shared compare unit.
module clt_seq (
   input  logic                   clock,
   input  logic                   reset,
   clt_req_if.sink                req,
   clt_rsp_if.source              rsp,
   input  clt_pkg::time_type      max_lease,
   input  clt_pkg::time_type      stale,
   output clt_pkg::slot_idx_type  rd_slot,
   output clt_pkg::store_cmd_type cmd,
   input  clt_pkg::entry_type     rd_entry,
   input  logic                   rd_valid,
   input  logic                   rd_seen,
   input  clt_pkg::count_type     count,
   output clt_pkg::cmp_op_type    cmp_op,
   output clt_pkg::mac_type       cmp_a,
   output clt_pkg::mac_type       cmp_b,
   output clt_pkg::time_type      cmp_limit,
   input  logic                   cmp_hit
);
   import clt_pkg::*;

   localparam slot_idx_type LAST_SLOT = SLOT_W'(LEASE_SLOTS - 1);

   state_type    state_ff, state_in;
   slot_idx_type idx_ff, idx_in;
   mac_type      mac_ff, mac_in;
   time_type     now_ff, now_in;
   logic         match_found_ff, match_found_in;
   slot_idx_type match_slot_ff, match_slot_in;
   logic         free_found_ff, free_found_in;
   slot_idx_type free_slot_ff, free_slot_in;
   logic [MASK_W-1:0] mask_ff, mask_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [MASK_W-1:0]      rsp_mask_ff, rsp_mask_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic        out_free;
   logic        is_last;
   logic        table_full;
   logic [63:0] idx_wide;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign is_last    = (idx_ff == LAST_SLOT);
   assign table_full = (count == CNT_W'(LEASE_SLOTS));
   assign idx_wide   = 64'(idx_ff);

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.slot         = rsp_slot_ff;
   assign rsp.removed_mask = rsp_mask_ff;
   assign rsp.lease_count  = rsp_count_ff;
   assign rd_slot          = idx_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) state_in = req.kind ? S_AGE_LEASE : S_MATCH;
         end
         S_MATCH: begin
            if ((rd_valid && cmp_hit) || is_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (out_free) state_in = S_IDLE;
         end
         S_AGE_LEASE: begin
            if (rd_valid && !cmp_hit) state_in = S_AGE_STALE;
            else if (is_last)         state_in = S_SWEEP_END;
         end
         S_AGE_STALE: begin
            state_in = is_last ? S_SWEEP_END : S_AGE_LEASE;
         end
         S_SWEEP_END: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, store commands and compare operands.
   always_comb begin
      idx_in         = idx_ff;
      mac_in         = mac_ff;
      now_in         = now_ff;
      match_found_in = match_found_ff;
      match_slot_in  = match_slot_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      mask_in        = mask_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_count_in   = rsp_count_ff;
      cmd.op         = SOP_NONE;
      cmd.slot       = idx_ff;
      cmd.mac        = mac_ff;
      cmd.now        = now_ff;
      cmp_op         = CMP_MAC_EQ;
      cmp_a          = rd_entry.mac;
      cmp_b          = mac_ff;
      cmp_limit      = max_lease;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               idx_in         = '0;
               mac_in         = req.station_mac;
               now_in         = req.now_ms;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               mask_in        = '0;
            end
         end
         S_MATCH: begin
            if (rd_valid && cmp_hit) begin
               match_found_in = 1'b1;
               match_slot_in  = idx_ff;
            end else begin
               // Keep the lowest free slot.
               if (!rd_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = idx_ff;
               end
               if (!is_last) idx_in = idx_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = '0;
               if (match_found_ff) begin
                  cmd.op        = SOP_REFRESH;
                  cmd.slot      = match_slot_ff;
                  rsp_status_in = ST_REFRESHED;
                  rsp_slot_in   = slot_field(match_slot_ff);
                  rsp_count_in  = count_field(count);
               end else if (free_found_ff && !table_full) begin
                  cmd.op        = SOP_ALLOC;
                  cmd.slot      = free_slot_ff;
                  rsp_status_in = ST_ADDED;
                  rsp_slot_in   = slot_field(free_slot_ff);
                  rsp_count_in  = count_field(count + 1'b1);
               end else begin
                  rsp_status_in = ST_FULL;
                  rsp_slot_in   = '0;
                  rsp_count_in  = count_field(count);
               end
            end
         end
         S_AGE_LEASE: begin
            cmp_op    = CMP_AGE_GT;
            cmp_a     = MAC_W'(now_ff);
            cmp_b     = MAC_W'(rd_entry.start);
            cmp_limit = max_lease;
            if (!rd_valid || cmp_hit) begin
               if (rd_valid) begin
                  cmd.op = SOP_REMOVE;
                  if (idx_wide < 64'(MASK_W)) mask_in[idx_wide[2:0]] = 1'b1;
               end
               if (!is_last) idx_in = idx_ff + 1'b1;
            end
         end
         S_AGE_STALE: begin
            cmp_op    = CMP_AGE_GT;
            cmp_a     = MAC_W'(now_ff);
            cmp_b     = MAC_W'(rd_entry.last_seen);
            cmp_limit = stale;
            if (!rd_seen && cmp_hit) begin
               cmd.op = SOP_REMOVE;
               if (idx_wide < 64'(MASK_W)) mask_in[idx_wide[2:0]] = 1'b1;
            end
            if (!is_last) idx_in = idx_ff + 1'b1;
         end
         S_SWEEP_END: begin
            if (out_free) begin
               cmd.op        = SOP_CLEAR_SEEN;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_SWEEP_DONE;
               rsp_slot_in   = '0;
               rsp_mask_in   = mask_ff;
               rsp_count_in  = count_field(count);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      mac_ff         <= mac_in;
      now_ff         <= now_in;
      match_found_ff <= match_found_in;
      match_slot_ff  <= match_slot_in;
      free_found_ff  <= free_found_in;
      free_slot_ff   <= free_slot_in;
      mask_ff        <= mask_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_count_ff   <= rsp_count_in;
   end

endmodule

// ===== verif/client_lease_table_top_tb.sv =====
// Self-checking testbench of the client lease table: directed and random station/sweep items.
`timescale 1ns / 100ps

module client_lease_table_top_tb;
   import clt_pkg::*;

   localparam bit KIND_STATION = 1'b0;
   localparam bit KIND_SWEEP   = 1'b1;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 230;
   localparam int MAC_POOL     = 10;

   typedef struct packed {
      status_type                status;
      logic [SLOT_OUT_W-1:0]     slot;
      logic [MASK_W-1:0]         removed;
      logic [COUNT_OUT_W-1:0]    count;
   } lease_result_type;

   // Lease table shadow: predicts each result item and checks the block's against it.
   class lease_result_board;
      time_type         max_lease;
      time_type         stale_limit;
      bit               occupied [LEASE_SLOTS];
      mac_type          owner [LEASE_SLOTS];
      time_type         granted [LEASE_SLOTS];
      time_type         last_heard [LEASE_SLOTS];
      bit               heard [LEASE_SLOTS];
      int               leases;
      lease_result_type awaited [$];
      int               mismatches;
      int               checked;

      function new();
         max_lease   = MAX_LEASE_RESET;
         stale_limit = STALE_RESET;
         for (int i = 0; i < LEASE_SLOTS; i++) begin
            occupied[i]   = 1'b0;
            owner[i]      = '0;
            granted[i]    = '0;
            last_heard[i] = '0;
            heard[i]      = 1'b0;
         end
         leases     = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, time_type value);
         if (idx == CSR_MAX_LEASE)
            max_lease = value;
         else if (idx == CSR_STALE)
            stale_limit = value;
      endfunction

      function void predict_item(bit kind, mac_type mac, time_type now);
         lease_result_type r;
         bit               done;
         time_type         held_for;
         time_type         idle_for;
         r.status  = ST_FULL;
         r.slot    = '0;
         r.removed = '0;
         done      = 1'b0;
         if (kind == KIND_STATION) begin
            for (int i = 0; i < LEASE_SLOTS; i++) begin
               if (!done && occupied[i] && owner[i] == mac) begin
                  last_heard[i] = now;
                  heard[i]      = 1'b1;
                  r.status      = ST_REFRESHED;
                  r.slot        = SLOT_OUT_W'(i);
                  done          = 1'b1;
               end
            end
            if (!done && leases < LEASE_SLOTS) begin
               for (int i = 0; i < LEASE_SLOTS; i++) begin
                  if (!done && !occupied[i]) begin
                     occupied[i]   = 1'b1;
                     owner[i]      = mac;
                     granted[i]    = now;
                     last_heard[i] = now;
                     heard[i]      = 1'b1;
                     leases++;
                     r.status      = ST_ADDED;
                     r.slot        = SLOT_OUT_W'(i);
                     done          = 1'b1;
                  end
               end
            end
         end else begin
            for (int i = 0; i < LEASE_SLOTS; i++) begin
               if (occupied[i]) begin
                  held_for = now - granted[i];
                  idle_for = now - last_heard[i];
                  if (held_for > max_lease || (!heard[i] && idle_for > stale_limit)) begin
                     occupied[i]   = 1'b0;
                     owner[i]      = '0;
                     granted[i]    = '0;
                     last_heard[i] = '0;
                     if (leases > 0)
                        leases--;
                     if (i < MASK_W)
                        r.removed[i] = 1'b1;
                  end
               end
               heard[i] = 1'b0;
            end
            r.status = ST_SWEEP_DONE;
         end
         r.count = COUNT_OUT_W'(leases);
         awaited.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(lease_result_type got);
         lease_result_type want;
         checked++;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no request waiting", checked));
         end else begin
            want = awaited.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("result %0d status got %0d expected %0d",
                                         checked, got.status, want.status));
            if (got.slot !== want.slot)
               report_mismatch($sformatf("result %0d slot got %0d expected %0d",
                                         checked, got.slot, want.slot));
            if (got.removed !== want.removed)
               report_mismatch($sformatf("result %0d removed_mask got %h expected %h",
                                         checked, got.removed, want.removed));
            if (got.count !== want.count)
               report_mismatch($sformatf("result %0d lease_count got %0d expected %0d",
                                         checked, got.count, want.count));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   clt_req_if req_ch ();
   clt_rsp_if rsp_ch ();

   client_lease_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lease_result_board board = new();

   int      send_idle_pct   = 0;
   int      recv_stall_pct  = 0;
   int      hold_off_cycles = 0;
   int      station_items   = 0;
   int      sweep_items     = 0;
   int      settings_used   = 0;
   mac_type mac_pool [MAC_POOL];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_item(bit kind, mac_type mac, time_type now);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.station_mac <= mac;
      req_ch.now_ms      <= now;
      do @(posedge clock); while (!req_ch.ready);
      board.predict_item(kind, mac, now);
      if (kind == KIND_SWEEP)
         sweep_items++;
      else
         station_items++;
   endtask

   // Drop valid, drain every outstanding result and let the sequencer settle.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (board.awaited.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limits(time_type lease_v, time_type stale_v);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_LEASE;
      csr_wdata <= lease_v;
      board.set_register(CSR_MAX_LEASE, lease_v);
      @(posedge clock);
      csr_index <= CSR_STALE;
      csr_wdata <= stale_v;
      board.set_register(CSR_STALE, stale_v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      time_type now;
      time_type lease_v;
      time_type stale_v;
      int       step_max;
      bit       kind;
      mac_type  mac;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_STATION;
      req_ch.station_mac <= '0;
      req_ch.now_ms      <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_MAX_LEASE;
      csr_wdata          <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fill the table, overflow it, refresh twice, then age leases out.
      write_limits(32'd1000, 32'd100);
      send_item(KIND_STATION, '0, '0);
      send_item(KIND_STATION, '1, '1);
      for (int i = 0; i < 6; i++)
         send_item(KIND_STATION, {16'hA5C3, 32'(i)}, 32'd10);
      send_item(KIND_STATION, 48'h8000_0000_0001, 32'd10);
      send_item(KIND_STATION, '0, 32'd5);
      send_item(KIND_STATION, '0, 32'd6);
      send_item(KIND_SWEEP, 48'h5555_5555_5555, 32'd50);
      send_item(KIND_STATION, {16'hA5C3, 32'd0}, 32'd200);
      send_item(KIND_SWEEP, '1, 32'd300);
      send_item(KIND_STATION, 48'h1234_5678_9ABC, 32'd400);
      send_item(KIND_SWEEP, '0, 32'd5000);
      send_item(KIND_SWEEP, '0, 32'd5001);
      wait_idle();
      // Zero limits: any elapsed time removes the lease.
      write_limits('0, '0);
      send_item(KIND_STATION, 48'h0000_0000_0042, 32'd7);
      send_item(KIND_SWEEP, '0, 32'd7);
      send_item(KIND_SWEEP, '0, 32'd8);
      wait_idle();
      // Full-scale limits: the largest wrapped age never exceeds them.
      write_limits('1, '1);
      send_item(KIND_STATION, 48'hFEDC_BA98_7654, 32'h8000_0000);
      send_item(KIND_SWEEP, '0, 32'h7FFF_FFFF);
      send_item(KIND_SWEEP, '0, 32'h7FFF_FFFF);

      now = $urandom;
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         case (p)
            0: begin lease_v = MAX_LEASE_RESET; stale_v = STALE_RESET; step_max = 30000; end
            1: begin
               lease_v = $urandom_range(200, 3000); stale_v = $urandom_range(20, 400);
               step_max = 100;
            end
            2: begin lease_v = '0; stale_v = '0; step_max = 3; end
            3: begin lease_v = '1; stale_v = '1; step_max = 1000; end
            4: begin lease_v = $urandom_range(200, 3000); stale_v = '1; step_max = 100; end
            5: begin lease_v = '1; stale_v = $urandom_range(20, 400); step_max = 100; end
            6: begin lease_v = $urandom; stale_v = $urandom; step_max = 2000; end
            default: begin
               lease_v = $urandom_range(100, 1500); stale_v = $urandom_range(10, 200);
               step_max = 60;
            end
         endcase
         write_limits(lease_v, stale_v);
         for (int k = 0; k < MAC_POOL; k++)
            mac_pool[k] = mac_type'({$urandom, $urandom});
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Stall the result side for a long stretch and keep offering items.
            if (p == 0 && n == 60)
               hold_off_cycles = 300;
            kind = ($urandom_range(0, 5) == 0) ? KIND_SWEEP : KIND_STATION;
            if ($urandom_range(0, 9) == 0)
               mac = mac_type'({$urandom, $urandom});
            else
               mac = mac_pool[$urandom_range(0, MAC_POOL - 1)];
            if ($urandom_range(0, 39) == 0)
               now = $urandom;
            else
               now = now + time_type'($urandom_range(0, step_max));
            send_item(kind, mac, now);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d station and %0d sweep items over %0d limit settings.",
               station_items, sweep_items, settings_used);
      $display("Checked %0d result items, %0d mismatches.", board.checked, board.mismatches);
      if (board.mismatches == 0 && board.awaited.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : result_sink
      lease_result_type got;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.status  = status_type'(rsp_ch.status);
            got.slot    = rsp_ch.slot;
            got.removed = rsp_ch.removed_mask;
            got.count   = rsp_ch.lease_count;
            board.check_result(got);
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no item moved for %0d cycles, %0d results outstanding.",
               QUIET_LIMIT, board.awaited.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
